// ===== sv/dri_pkg.sv =====
// ----------------------------------------------------------------------------
// dri_pkg
// Shared widths, reset values, register map and pipeline types for the
// dead-reckoning integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package dri_pkg;

  localparam int NUM_AXES = 3;
  localparam int ACCEL_W  = 17;  // raw acceleration
  localparam int COND_W   = 18;  // after dead band and gravity removal
  localparam int GRAV_W   = 15;
  localparam int RUN_W    = 16;
  localparam int WORD_W   = 32;  // velocity, displacement
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic signed [ACCEL_W-1:0] BAND_LOW_RST   = -17'sd64;
  localparam logic signed [ACCEL_W-1:0] BAND_HIGH_RST  = 17'sd64;
  localparam logic [GRAV_W-1:0]         GRAVITY_RST    = 15'd14890;
  localparam logic [RUN_W-1:0]          ZERO_LIMIT_RST = 16'd25;

  typedef enum logic [1:0] {
    REG_BAND_LOW   = 2'd0,
    REG_BAND_HIGH  = 2'd1,
    REG_GRAVITY    = 2'd2,
    REG_ZERO_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ACCEL_W-1:0] band_low;
    logic [ACCEL_W-1:0] band_high;
    logic [RUN_W-1:0]   zero_run_limit;
  } lane_cfg_t;

  // load strobes: an item moves into the stage at this edge
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] dhalf;  // floor((v_old + v_new) / 2)
  } lane_res_t;

endpackage

`default_nettype wire

// ===== sv/dri_in_if.sv =====
// ----------------------------------------------------------------------------
// dri_in_if
// Acceleration sample channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dri_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dri_pkg::ACCEL_W-1:0]  accel_x;
  logic signed [dri_pkg::ACCEL_W-1:0]  accel_y;
  logic signed [dri_pkg::ACCEL_W-1:0]  accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

`default_nettype wire

// ===== sv/dri_out_if.sv =====
// ----------------------------------------------------------------------------
// dri_out_if
// Velocity / displacement result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dri_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dri_pkg::WORD_W-1:0]  speed_x;
  logic signed [dri_pkg::WORD_W-1:0]  speed_y;
  logic signed [dri_pkg::WORD_W-1:0]  speed_z;
  logic signed [dri_pkg::WORD_W-1:0]  place_x;
  logic signed [dri_pkg::WORD_W-1:0]  place_y;
  logic signed [dri_pkg::WORD_W-1:0]  place_z;

  modport source (output valid, speed_x, speed_y, speed_z, place_x, place_y, place_z,
                  input ready);
  modport sink   (input valid, speed_x, speed_y, speed_z, place_x, place_y, place_z,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/dead_reckoning_integrator_top.sv =====
// ----------------------------------------------------------------------------
// dead_reckoning_integrator_top
// Three-axis trapezoidal double integrator with dead band, gravity removal
// and per-axis zero-velocity update.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one acceleration sample (accel_x/y/z) per transaction.
//   out_ch : one result per sample: speed_x/y/z (velocity after any zero
//            clear) and place_x/y/z (displacement, wraps at 32 bits).
//   cfg_*  : APB-style register port, pready tied high. Byte address 4*i:
//            0 band_low, 1 band_high, 2 gravity_offset, 3 zero_run_limit.
//            Write only while the block is drained.
// Pipeline: four register stages, the first loaded at the input transaction
//   edge (stage A dead band/accel half-sum, B velocity + ZUPT, C velocity
//   half-sum, D merge and displacement accumulate); out_ch.valid rises when
//   stage D is loaded.
// Throughput: one sample per cycle while out_ch.ready is high; the loop that
//   sets it is the per-axis 32-bit velocity add in stage B.
// Reset (rst_n low, synchronous): velocity, displacement, prior acceleration
//   and zero counters clear; registers return to their defaults; pipeline
//   empties.
// Stall: if out_ch.ready is low the result holds; empty stages upstream keep
//   taking samples until the four stages are full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_reckoning_integrator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  dri_in_if.sink                      in_ch,
  dri_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dri_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [dri_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [dri_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import dri_pkg::*;

  // ---- configuration registers ----
  logic [ACCEL_W-1:0] band_low_r;
  logic [ACCEL_W-1:0] band_high_r;
  logic [GRAV_W-1:0]  gravity_r;
  logic [RUN_W-1:0]   zero_limit_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r   <= BAND_LOW_RST;
      band_high_r  <= BAND_HIGH_RST;
      gravity_r    <= GRAVITY_RST;
      zero_limit_r <= ZERO_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BAND_LOW:   band_low_r   <= cfg_pwdata[ACCEL_W-1:0];
        REG_BAND_HIGH:  band_high_r  <= cfg_pwdata[ACCEL_W-1:0];
        REG_GRAVITY:    gravity_r    <= cfg_pwdata[GRAV_W-1:0];
        REG_ZERO_LIMIT: zero_limit_r <= cfg_pwdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back; the band edges are sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_BAND_LOW:   cfg_prdata = {{(APB_DW-ACCEL_W){band_low_r[ACCEL_W-1]}}, band_low_r};
      REG_BAND_HIGH:  cfg_prdata = {{(APB_DW-ACCEL_W){band_high_r[ACCEL_W-1]}}, band_high_r};
      REG_GRAVITY:    cfg_prdata = {{(APB_DW-GRAV_W){1'b0}}, gravity_r};
      REG_ZERO_LIMIT: cfg_prdata = {{(APB_DW-RUN_W){1'b0}}, zero_limit_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---- pipeline control ----
  // Each stage advances when it is empty or when the stage after it moves.
  logic       va_r, vb_r, vc_r, out_valid_r;
  logic       en_a, en_b, en_c, en_d;
  logic       ld_d;
  pipe_ctrl_t ctrl;

  always_comb begin
    en_d      = !out_valid_r || out_ch.ready;
    en_c      = !vc_r || en_d;
    en_b      = !vb_r || en_c;
    en_a      = !va_r || en_b;
    ctrl.ld_a = in_ch.valid && en_a;
    ctrl.ld_b = va_r && en_b;
    ctrl.ld_c = vb_r && en_c;
    ld_d      = vc_r && en_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) va_r        <= in_ch.valid;
      if (en_b) vb_r        <= va_r;
      if (en_c) vc_r        <= vb_r;
      if (en_d) out_valid_r <= vc_r;
    end
  end

  assign in_ch.ready = en_a;

  // ---- lanes ----
  lane_cfg_t          lane_cfg;
  logic [ACCEL_W-1:0] accel [NUM_AXES];
  logic [GRAV_W-1:0]  grav  [NUM_AXES];
  lane_res_t          res   [NUM_AXES];
  logic [WORD_W-1:0]  speed [NUM_AXES];
  logic [WORD_W-1:0]  place [NUM_AXES];

  assign lane_cfg.band_low       = band_low_r;
  assign lane_cfg.band_high      = band_high_r;
  assign lane_cfg.zero_run_limit = zero_limit_r;

  assign accel[0] = in_ch.accel_x;
  assign accel[1] = in_ch.accel_y;
  assign accel[2] = in_ch.accel_z;
  assign grav[0]  = '0;
  assign grav[1]  = '0;
  assign grav[2]  = gravity_r;   // gravity only on z

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    dri_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .cfg            (lane_cfg),
      .gravity_offset (grav[g]),
      .accel          (accel[g]),
      .res            (res[g])
    );
  end

  dri_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ld_d  (ld_d),
    .res   (res),
    .speed (speed),
    .place (place)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.speed_x = speed[0];
  assign out_ch.speed_y = speed[1];
  assign out_ch.speed_z = speed[2];
  assign out_ch.place_x = place[0];
  assign out_ch.place_y = place[1];
  assign out_ch.place_z = place[2];

  // ---- assertions ----
  logic [2:0] occupancy;
  assign occupancy = 3'($countones({va_r, vb_r, vc_r, out_valid_r}));

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !va_r && !vb_r && !vc_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (va_r && vb_r && vc_r && out_valid_r))
    else $error("input stalled with an empty stage");

  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.ld_a && !(out_valid_r && out_ch.ready)) |=> occupancy == $past(occupancy) + 3'd1)
    else $error("transaction lost or duplicated in pipeline");

  a_occ_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctrl.ld_a && out_valid_r && out_ch.ready) |=> occupancy == $past(occupancy) - 3'd1)
    else $error("transaction lost or duplicated in pipeline");

endmodule

`default_nettype wire

// ===== sv/dri_lane.sv =====
// ----------------------------------------------------------------------------
// dri_lane
// One axis: dead band, gravity removal, velocity integration with
// zero-velocity update, and the displacement increment. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dri_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dri_pkg::pipe_ctrl_t                 ctrl,
  input  dri_pkg::lane_cfg_t                  cfg,
  input  logic [dri_pkg::GRAV_W-1:0]          gravity_offset,
  input  logic signed [dri_pkg::ACCEL_W-1:0]  accel,
  output dri_pkg::lane_res_t                  res
);
  import dri_pkg::*;

  // stage A
  logic              in_band;
  logic [ACCEL_W-1:0] dead;
  logic [COND_W-1:0] cond;
  logic [COND_W:0]   asum;
  logic [COND_W-1:0] prior_r;
  logic [COND_W-1:0] half_a_r;
  logic              zero_a_r;

  // stage B
  logic [WORD_W-1:0] vel_sum;
  logic [RUN_W-1:0]  run_nxt;
  logic              clear;
  logic [WORD_W-1:0] vel_r;
  logic [RUN_W-1:0]  run_r;
  logic [WORD_W-1:0] vold_b_r;
  logic [WORD_W-1:0] vnew_b_r;
  logic [WORD_W-1:0] spd_b_r;

  // stage C
  logic [WORD_W:0]   vpair;
  logic [WORD_W-1:0] dhalf_c_r;
  logic [WORD_W-1:0] spd_c_r;

  always_comb begin
    in_band = ($signed(accel) < $signed(cfg.band_high)) &&
              ($signed(accel) > $signed(cfg.band_low));
    dead    = in_band ? '0 : accel;
    cond    = {dead[ACCEL_W-1], dead} - {{(COND_W-GRAV_W){1'b0}}, gravity_offset};
    asum    = {prior_r[COND_W-1], prior_r} + {cond[COND_W-1], cond};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
    end else if (ctrl.ld_a) begin
      prior_r <= cond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_a) begin
      half_a_r <= asum[COND_W:1];  // arithmetic floor halving
      zero_a_r <= (cond == '0);
    end
  end

  always_comb begin
    vel_sum = vel_r + {{(WORD_W-COND_W){half_a_r[COND_W-1]}}, half_a_r};
    if (!zero_a_r) begin
      run_nxt = '0;
    end else if (run_r < cfg.zero_run_limit) begin
      run_nxt = run_r + 1'b1;
    end else begin
      run_nxt = run_r;
    end
    clear = (run_nxt >= cfg.zero_run_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
      run_r <= '0;
    end else if (ctrl.ld_b) begin
      vel_r <= clear ? '0 : vel_sum;
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_b) begin
      vold_b_r <= vel_r;
      vnew_b_r <= vel_sum;
      spd_b_r  <= clear ? '0 : vel_sum;
    end
  end

  // exact 33-bit sum, then floor halving
  assign vpair = {vold_b_r[WORD_W-1], vold_b_r} + {vnew_b_r[WORD_W-1], vnew_b_r};

  always_ff @(posedge clk) begin
    if (ctrl.ld_c) begin
      dhalf_c_r <= vpair[WORD_W:1];
      spd_c_r   <= spd_b_r;
    end
  end

  assign res.speed = spd_c_r;
  assign res.dhalf = dhalf_c_r;

endmodule

`default_nettype wire

// ===== sv/dri_merge.sv =====
// ----------------------------------------------------------------------------
// dri_merge
// Output stage: collects the three lanes, accumulates displacement and holds
// the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dri_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld_d,
  input  dri_pkg::lane_res_t          res   [dri_pkg::NUM_AXES],
  output logic [dri_pkg::WORD_W-1:0]  speed [dri_pkg::NUM_AXES],
  output logic [dri_pkg::WORD_W-1:0]  place [dri_pkg::NUM_AXES]
);
  import dri_pkg::*;

  logic [WORD_W-1:0] place_r [NUM_AXES];
  logic [WORD_W-1:0] speed_r [NUM_AXES];

  // the displacement state is the output register itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        place_r[i] <= '0;
      end
    end else if (ld_d) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        place_r[i] <= place_r[i] + res[i].dhalf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        speed_r[i] <= res[i].speed;
      end
    end
  end

  assign speed = speed_r;
  assign place = place_r;

endmodule

`default_nettype wire
